@@ rtl/tlphs_pkg.sv @@
// Shared widths, register indexes and mode codes for the triggered looping phasor.
`timescale 1ns / 1ps
`default_nettype none

package tlphs_pkg;

    // Field widths of the stream beats and the configuration port.
    localparam int DATA_W    = 32;
    localparam int TRIG_W    = 16;
    localparam int MODE_W    = 2;
    localparam int IN_W      = TRIG_W + DATA_W;
    localparam int CFG_IDX_W = 3;

    // Working width of the shared adder; holds every intermediate sum exactly.
    localparam int ALU_W = DATA_W + 3;

    // Default number of fraction bits of the fixed-point format.
    localparam int FRAC_BITS_DEF = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_POS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_POS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_FIRST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LAST  = 3'd4;

    // Loop modes; any other code behaves as ping-pong.
    localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRAP = 2'd1;

endpackage

`default_nettype wire

@@ rtl/triggered_looping_phasor.sv @@
// Top level of the triggered looping phasor: sequencer, shared adder, divider and multiplier.
`timescale 1ns / 1ps
`default_nettype none

// One input beat (trigger, step_rate) yields one output beat holding the phase level
// before the advance. A sample without a rising trigger goes through acceptance,
// the advance, up to two loop-handling steps and the range clip before the block is
// ready again. A rising trigger adds a restoring divider, which produces one quotient
// bit per cycle on the shared 35-bit adder, then a multiplication step and a restart
// sum. The input side is not ready while a sample is being worked on; the result sits
// in an output register, so the next sample can be accepted while it waits. If that
// earlier result has still not been taken when the next sample reaches its advance
// step, the advance step holds until it is taken. Configuration writes are taken
// every cycle and must only happen while the block is idle.
module triggered_looping_phasor
    import tlphs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // Input stream
    input  wire                  i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  wire  [IN_W-1:0]      i_s_axis_tdata,   // [15:0] trigger, [47:16] step_rate
    // Output stream
    output logic                 o_m_axis_tvalid,
    input  wire                  i_m_axis_tready,
    output logic [DATA_W-1:0]    o_m_axis_tdata,   // [31:0] phase_level
    // Configuration write channel
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0] i_cfg_addr,
    input  wire  [DATA_W-1:0]    i_cfg_data
);

    localparam int QUO_W  = FRAC_BITS + 1;
    localparam int PROD_W = DATA_W + QUO_W + 1;
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_RST  = 4'd3;
    localparam logic [3:0] S_ADV  = 4'd4;
    localparam logic [3:0] S_SPAN = 4'd5;
    localparam logic [3:0] S_WRAP = 4'd6;
    localparam logic [3:0] S_PP   = 4'd7;
    localparam logic [3:0] S_CLIP = 4'd8;

    localparam logic signed [ALU_W-1:0] SAT_MAX = ALU_W'(2147483647);
    localparam logic signed [ALU_W-1:0] SAT_MIN = -ALU_W'(64'sd2147483648);

    // Configuration registers
    logic signed [DATA_W-1:0] r_start_pos, r_end_pos, r_loop_first, r_loop_last;
    logic [MODE_W-1:0]        r_loop_mode;

    // Persistent state
    logic signed [DATA_W-1:0] r_level;
    logic signed [TRIG_W-1:0] r_prev;
    logic                     r_dir;

    // Per-sample working registers
    logic [3:0]               r_state, n_state;
    logic signed [TRIG_W-1:0] r_trig;
    logic signed [DATA_W-1:0] r_rate;
    logic [TRIG_W-1:0]        r_rem, r_den;
    logic [QUO_W-1:0]         r_quo;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ALU_W-1:0]  r_lv, r_span;
    logic                     r_inloop;

    // Output register
    logic                     r_out_vld;
    logic [DATA_W-1:0]        r_out_data;

    // Ordered bounds, sign-extended to the adder width
    logic signed [ALU_W-1:0]  lo, hi, ls, le;
    logic signed [ALU_W-1:0]  alu_a, alu_b, alu_y, sat_y;
    logic                     alu_sub;
    logic signed [TRIG_W-1:0] in_trig;
    logic signed [DATA_W-1:0] in_rate;
    logic [TRIG_W:0]          in_den, in_rem;
    logic                     in_fire, rise, out_free, mode_pp, in_loop_now;

    assign in_trig  = i_s_axis_tdata[TRIG_W-1:0];
    assign in_rate  = i_s_axis_tdata[IN_W-1:TRIG_W];
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign rise     = (r_prev <= 0) && (in_trig > 0);
    assign in_den   = {in_trig[TRIG_W-1], in_trig} - {r_prev[TRIG_W-1], r_prev};
    assign in_rem   = (TRIG_W + 1)'(0) - {r_prev[TRIG_W-1], r_prev};
    assign out_free = !r_out_vld || i_m_axis_tready;
    assign mode_pp  = (r_loop_mode != MODE_OFF) && (r_loop_mode != MODE_WRAP);

    // Swap the range and loop bounds when they are given in reverse.
    always_comb begin
        if (r_end_pos < r_start_pos) begin
            lo = ALU_W'(r_end_pos);
            hi = ALU_W'(r_start_pos);
        end else begin
            lo = ALU_W'(r_start_pos);
            hi = ALU_W'(r_end_pos);
        end
        if (r_loop_last < r_loop_first) begin
            ls = ALU_W'(r_loop_last);
            le = ALU_W'(r_loop_first);
        end else begin
            ls = ALU_W'(r_loop_first);
            le = ALU_W'(r_loop_last);
        end
    end

    assign in_loop_now = (r_lv >= ls) && (r_lv <= le);

    // Shared adder: operands are chosen by the sequencer state.
    always_comb begin
        alu_a   = r_lv;
        alu_b   = ALU_W'(r_rate);
        alu_sub = 1'b0;
        case (r_state)
            S_DIV: begin
                alu_a   = {{(ALU_W - TRIG_W - 1){1'b0}}, r_rem, 1'b0};
                alu_b   = {{(ALU_W - TRIG_W){1'b0}}, r_den};
                alu_sub = 1'b1;
            end
            S_RST: begin
                alu_a = ALU_W'(r_start_pos);
                alu_b = {r_prod[PROD_W-1], r_prod[PROD_W-1:FRAC_BITS]};
            end
            S_ADV: begin
                alu_sub = mode_pp && in_loop_now && r_dir;
            end
            S_SPAN: begin
                alu_a   = le;
                alu_b   = ls;
                alu_sub = 1'b1;
            end
            S_WRAP: begin
                alu_b   = r_span;
                alu_sub = !r_rate[DATA_W-1];
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
        alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    // Saturation of the restart point to the 32-bit range.
    always_comb begin
        if (alu_y > SAT_MAX) begin
            sat_y = SAT_MAX;
        end else if (alu_y < SAT_MIN) begin
            sat_y = SAT_MIN;
        end else begin
            sat_y = alu_y;
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = rise ? S_DIV : S_ADV;
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(FRAC_BITS - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_RST;
            S_RST:  n_state = S_ADV;
            S_ADV: begin
                if (out_free) begin
                    if (r_loop_mode == MODE_OFF) begin
                        n_state = S_CLIP;
                    end else if (r_loop_mode == MODE_WRAP) begin
                        n_state = S_SPAN;
                    end else begin
                        n_state = S_PP;
                    end
                end
            end
            S_SPAN: n_state = S_WRAP;
            S_WRAP: n_state = S_CLIP;
            S_PP:   n_state = S_CLIP;
            S_CLIP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and persistent phasor state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_start_pos  <= '0;
            r_end_pos    <= DATA_W'(2147483647);
            r_loop_mode  <= MODE_OFF;
            r_loop_first <= '0;
            r_loop_last  <= DATA_W'(2147483647);
            r_level      <= '0;
            r_prev       <= '0;
            r_dir        <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_addr)
                    CFG_START_POS:  r_start_pos  <= i_cfg_data;
                    CFG_END_POS:    r_end_pos    <= i_cfg_data;
                    CFG_LOOP_MODE:  r_loop_mode  <= i_cfg_data[MODE_W-1:0];
                    CFG_LOOP_FIRST: r_loop_first <= i_cfg_data;
                    CFG_LOOP_LAST:  r_loop_last  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            // The output beat is raised by the advance step and dropped once taken.
            if ((r_state == S_ADV) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_RST: begin
                    if (mode_pp) begin
                        r_dir <= 1'b1;
                    end
                end
                S_PP: begin
                    if (r_inloop && ((r_lv > le) || (r_lv < ls))) begin
                        r_dir <= !r_dir;
                    end
                end
                S_CLIP: begin
                    if (r_lv < lo) begin
                        r_level <= lo[DATA_W-1:0];
                    end else if (r_lv > hi) begin
                        r_level <= hi[DATA_W-1:0];
                    end else begin
                        r_level <= r_lv[DATA_W-1:0];
                    end
                    r_prev <= r_trig;
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers of the sample in flight.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_trig <= in_trig;
                    r_rate <= in_rate;
                    r_den  <= in_den[TRIG_W-1:0];
                    r_rem  <= in_rem[TRIG_W-1:0];
                    r_quo  <= QUO_W'(1);
                    r_cnt  <= '0;
                    r_lv   <= ALU_W'(r_level);
                end
            end
            S_DIV: begin
                // One restoring division step per cycle.
                if (!alu_y[ALU_W-1]) begin
                    r_rem <= alu_y[TRIG_W-1:0];
                    r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[TRIG_W-2:0], 1'b0};
                    r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + CNT_W'(1);
            end
            S_MUL: begin
                r_prod <= PROD_W'(r_rate) * $signed({1'b0, r_quo});
            end
            S_RST: begin
                r_lv <= sat_y;
            end
            S_ADV: begin
                if (out_free) begin
                    r_out_data <= r_lv[DATA_W-1:0];
                    r_inloop   <= in_loop_now;
                    r_lv       <= alu_y;
                end
            end
            S_SPAN: begin
                r_span <= alu_y;
            end
            S_WRAP: begin
                if ((!r_rate[DATA_W-1] && (r_lv > le)) ||
                    (r_rate[DATA_W-1] && (r_lv < ls))) begin
                    r_lv <= alu_y;
                end
            end
            S_PP: begin
                if (r_inloop) begin
                    if (r_lv > le) begin
                        r_lv <= le;
                    end else if (r_lv < ls) begin
                        r_lv <= ls;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    // The partial remainder always stays below the divisor.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    // The restart fraction lies in [1, 2): its integer bit is set.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RST) |-> r_quo[QUO_W-1])
        else $error("restart fraction out of range");

    // A new result only appears from the advance step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == S_ADV))
        else $error("output beat raised outside the advance step");

    // A ping-pong level that started inside the loop ends inside the loop.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CLIP) && mode_pp && r_inloop) |-> ((r_lv >= ls) && (r_lv <= le)))
        else $error("ping-pong level left the loop");

endmodule

`default_nettype wire
